@@ rtl/sdlt_pkg.sv @@
// Shared types, constants and helper functions for the stereo dual-LFO tremolo.
// Holds the cosine ROM image, which is computed at elaboration time.
// No dependencies; every other file in rtl/ uses this package.
`default_nettype none

package sdlt_pkg;

   localparam int SAMPLE_BITS = 24;
   localparam int PHASE_BITS  = 32;
   localparam int COS_ENTRIES = 1024;
   localparam int COS_ADDR_W  = $clog2(COS_ENTRIES);
   localparam int COS_W       = 18;
   localparam int STEP_W      = 32;
   localparam int GAIN_W      = 17;

   // Envelope 65536 + cos spans 0..131072 and is carried as a signed operand.
   localparam int ENV_W   = 19;
   localparam int SH_W    = SAMPLE_BITS + 2;
   localparam int SUM_W   = SAMPLE_BITS + 3;
   localparam int PRE_W   = SAMPLE_BITS + 2;
   localparam int MUL_A_W = SAMPLE_BITS + 3;
   localparam int MUL_B_W = ENV_W;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int ACC_W   = PROD_W + 2;

   localparam logic [GAIN_W-1:0] GAIN_UNITY = GAIN_W'(65536);
   localparam logic signed [ENV_W-1:0] ENV_UNITY = ENV_W'(65536);
   localparam logic signed [ACC_W-1:0] HALF_Q16 = ACC_W'(longint'(1) << 15);
   localparam logic signed [ACC_W-1:0] HALF_Q17 = ACC_W'(longint'(1) << 16);

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      CSR_LEFT_STEP,
      CSR_RIGHT_STEP,
      CSR_WET_MIX,
      CSR_STEREO_WIDTH
   } csr_index_type;

   typedef struct packed {
      logic signed [STEP_W-1:0] left_step;
      logic signed [STEP_W-1:0] right_step;
      logic [GAIN_W-1:0]        wet_mix;
      logic [GAIN_W-1:0]        stereo_width;
   } cfg_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_INIT_Q16,
      ACC_INIT_Q17,
      ACC_ADD
   } acc_op_type;

   typedef struct packed {
      logic                        mul_en;
      acc_op_type                  acc_op;
      logic signed [MUL_A_W-1:0]   a;
      logic signed [MUL_B_W-1:0]   b;
   } mac_ctl_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_ROM_L,
      ST_ROM_R,
      ST_SHL_MUL,
      ST_SHL_ADD,
      ST_SHR_MUL,
      ST_SHR_ADD,
      ST_WL_MUL1,
      ST_WL_ADD1,
      ST_WL_MUL2,
      ST_WL_ADD2,
      ST_WR_MUL1,
      ST_WR_ADD1,
      ST_WR_MUL2,
      ST_WR_ADD2,
      ST_OL_MUL1,
      ST_OL_ADD1,
      ST_OL_MUL2,
      ST_OL_ADD2,
      ST_OR_MUL1,
      ST_OR_ADD1,
      ST_OR_MUL2,
      ST_OR_ADD2,
      ST_DONE
   } state_type;

   typedef logic signed [COS_W-1:0] cos_rom_type [COS_ENTRIES];

   localparam longint Q30_ONE   = longint'(1) << 30;
   localparam longint PI_Q30    = 64'sd3373259426;
   localparam longint N_ENTRIES = longint'(COS_ENTRIES);

   // Builds round(65536*cos(2*pi*k/N)) with a folded Taylor series in Q30.
   function automatic cos_rom_type build_cos_rom();
      cos_rom_type rom;
      longint      kf;
      longint      w;
      longint      x;
      longint      x2;
      longint      t;
      logic        neg;
      for (int k = 0; k < COS_ENTRIES; k++) begin
         kf = (longint'(k) <= N_ENTRIES - longint'(k)) ? longint'(k) : N_ENTRIES - longint'(k);
         w = 2 * kf;
         neg = 1'b0;
         if (2 * w <= N_ENTRIES) begin
            x = (PI_Q30 * w) / N_ENTRIES;
         end else begin
            x = (PI_Q30 * (N_ENTRIES - w)) / N_ENTRIES;
            neg = 1'b1;
         end
         x2 = (x * x) / Q30_ONE;
         t = Q30_ONE;
         t = Q30_ONE - (x2 * t) / (132 * Q30_ONE);
         t = Q30_ONE - (x2 * t) / (90 * Q30_ONE);
         t = Q30_ONE - (x2 * t) / (56 * Q30_ONE);
         t = Q30_ONE - (x2 * t) / (30 * Q30_ONE);
         t = Q30_ONE - (x2 * t) / (12 * Q30_ONE);
         t = Q30_ONE - (x2 * t) / (2 * Q30_ONE);
         if (t < 0) begin
            t = 0;
         end
         if (t > Q30_ONE) begin
            t = Q30_ONE;
         end
         t = (t + 8192) >>> 14;
         rom[k] = neg ? COS_W'(-t) : COS_W'(t);
      end
      return rom;
   endfunction

   localparam cos_rom_type COS_ROM = build_cos_rom();

   function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
      input logic signed [PRE_W-1:0] v
   );
      logic signed [SAMPLE_BITS-1:0] r;
      if ((v[PRE_W-1:SAMPLE_BITS-1] == '0) || (v[PRE_W-1:SAMPLE_BITS-1] == '1)) begin
         r = v[SAMPLE_BITS-1:0];
      end else if (v[PRE_W-1]) begin
         r = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
         r = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end
      return r;
   endfunction

   // Gains above one count as one.
   function automatic logic [GAIN_W-1:0] clamp_unity(input logic [GAIN_W-1:0] v);
      return v[GAIN_W-1] ? GAIN_UNITY : v;
   endfunction

endpackage

`default_nettype wire

@@ rtl/sdlt_csr.sv @@
// Configuration register bank behind the APB-style port.
// Depends on sdlt_pkg for register indexes and the cfg_type bundle.
`default_nettype none

module sdlt_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [sdlt_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [sdlt_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic      [sdlt_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                                  pready,
   output sdlt_pkg::cfg_type                     cfg
);

   sdlt_pkg::cfg_type       cfg_ff;
   sdlt_pkg::cfg_type       cfg_in;
   sdlt_pkg::csr_index_type index;
   logic                    wr_en;

   assign pready = 1'b1;
   assign index  = sdlt_pkg::csr_index_type'(paddr[3:2]);
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      prdata = '0;
      case (index)
         sdlt_pkg::CSR_LEFT_STEP: begin
            prdata = cfg_ff.left_step;
            if (wr_en) begin
               cfg_in.left_step = pwdata;
            end
         end
         sdlt_pkg::CSR_RIGHT_STEP: begin
            prdata = cfg_ff.right_step;
            if (wr_en) begin
               cfg_in.right_step = pwdata;
            end
         end
         sdlt_pkg::CSR_WET_MIX: begin
            prdata = sdlt_pkg::CSR_DATA_W'(cfg_ff.wet_mix);
            if (wr_en) begin
               cfg_in.wet_mix = pwdata[sdlt_pkg::GAIN_W-1:0];
            end
         end
         sdlt_pkg::CSR_STEREO_WIDTH: begin
            prdata = sdlt_pkg::CSR_DATA_W'(cfg_ff.stereo_width);
            if (wr_en) begin
               cfg_in.stereo_width = pwdata[sdlt_pkg::GAIN_W-1:0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.left_step    <= '0;
         cfg_ff.right_step   <= '0;
         cfg_ff.wet_mix      <= '0;
         cfg_ff.stereo_width <= sdlt_pkg::GAIN_UNITY;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ rtl/sdlt_cos_rom.sv @@
// Cosine ROM with a registered read port, one entry per cycle.
// The image comes from sdlt_pkg::COS_ROM.
`default_nettype none

module sdlt_cos_rom (
   input  wire logic                              clock,
   input  wire logic [sdlt_pkg::COS_ADDR_W-1:0]   addr,
   output logic signed [sdlt_pkg::COS_W-1:0]      rd_data
);

   logic signed [sdlt_pkg::COS_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      rd_data_ff <= sdlt_pkg::COS_ROM[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/sdlt_mac.sv @@
// Shared multiply-accumulate unit: a registered product feeds an accumulator
// that can be preset to a rounding constant. Depends on sdlt_pkg.
`default_nettype none

module sdlt_mac (
   input  wire logic                           clock,
   input  wire sdlt_pkg::mac_ctl_type          ctl,
   output logic signed [sdlt_pkg::ACC_W-1:0]   acc
);

   logic signed [sdlt_pkg::PROD_W-1:0] prod_ff;
   logic signed [sdlt_pkg::PROD_W-1:0] prod_in;
   logic signed [sdlt_pkg::ACC_W-1:0]  acc_ff;
   logic signed [sdlt_pkg::ACC_W-1:0]  acc_in;

   always_comb begin
      prod_in = ctl.mul_en ? sdlt_pkg::PROD_W'(ctl.a * ctl.b) : prod_ff;
      case (ctl.acc_op)
         sdlt_pkg::ACC_HOLD:     acc_in = acc_ff;
         sdlt_pkg::ACC_INIT_Q16: acc_in = sdlt_pkg::HALF_Q16;
         sdlt_pkg::ACC_INIT_Q17: acc_in = sdlt_pkg::HALF_Q17;
         sdlt_pkg::ACC_ADD:      acc_in = acc_ff + sdlt_pkg::ACC_W'(prod_ff);
         default:                acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign acc = acc_ff;

endmodule

`default_nettype wire

@@ rtl/stereo_dual_lfo_tremolo_core.sv @@
// Top level of the stereo dual-LFO tremolo: sequencer, phase accumulators and
// output register around sdlt_csr, sdlt_cos_rom and sdlt_mac. Depends on sdlt_pkg.
//
//   Channel   Direction  Handshake                     Payload
//   req_      in         req_valid / req_stall         req_in_sample
//   rsp_      out        rsp_valid / rsp_stall         rsp_left_out, rsp_right_out
//   config    in/out     psel, penable, pwrite, pready paddr, pwdata, prdata
//
// Each transaction runs from acceptance through two ROM reads and ten
// multiply-accumulate terms, each a MUL state on the shared multiplier and an
// ADD state on the accumulator. Reset is synchronous and returns the
// phases to zero and the registers to their defaults. A new transaction is taken
// while a result waits in the output register; rsp_stall only holds the
// sequencer in its last state when the output register is still occupied.
`default_nettype none

module stereo_dual_lfo_tremolo_core (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic signed [sdlt_pkg::SAMPLE_BITS-1:0] req_in_sample,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic signed [sdlt_pkg::SAMPLE_BITS-1:0]    rsp_left_out,
   output logic signed [sdlt_pkg::SAMPLE_BITS-1:0]    rsp_right_out,
   input  wire logic                                  psel,
   input  wire logic                                  penable,
   input  wire logic                                  pwrite,
   input  wire logic [sdlt_pkg::CSR_ADDR_W-1:0]       paddr,
   input  wire logic [sdlt_pkg::CSR_DATA_W-1:0]       pwdata,
   output logic      [sdlt_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                       pready
);

   localparam int SB = sdlt_pkg::SAMPLE_BITS;
   localparam int PB = sdlt_pkg::PHASE_BITS;
   localparam int AW = sdlt_pkg::COS_ADDR_W;

   sdlt_pkg::cfg_type     cfg;
   sdlt_pkg::mac_ctl_type mac_ctl;
   sdlt_pkg::state_type   state_ff;
   sdlt_pkg::state_type   state_in;

   logic signed [sdlt_pkg::ACC_W-1:0] acc;
   logic signed [sdlt_pkg::COS_W-1:0] rom_data;
   logic [AW-1:0]                     rom_addr;

   logic [PB-1:0]                     left_phase_ff;
   logic [PB-1:0]                     left_phase_in;
   logic [PB-1:0]                     right_phase_ff;
   logic [PB-1:0]                     right_phase_in;
   logic signed [SB-1:0]              s_ff;
   logic signed [SB-1:0]              s_in;
   logic signed [sdlt_pkg::ENV_W-1:0] env_l_ff;
   logic signed [sdlt_pkg::ENV_W-1:0] env_l_in;
   logic signed [sdlt_pkg::ENV_W-1:0] env_r_ff;
   logic signed [sdlt_pkg::ENV_W-1:0] env_r_in;
   logic signed [sdlt_pkg::SH_W-1:0]  shl_ff;
   logic signed [sdlt_pkg::SH_W-1:0]  shl_in;
   logic signed [sdlt_pkg::SH_W-1:0]  shr_ff;
   logic signed [sdlt_pkg::SH_W-1:0]  shr_in;
   logic signed [sdlt_pkg::SH_W-1:0]  wl_ff;
   logic signed [sdlt_pkg::SH_W-1:0]  wl_in;
   logic signed [sdlt_pkg::SH_W-1:0]  wr_ff;
   logic signed [sdlt_pkg::SH_W-1:0]  wr_in;
   logic signed [SB-1:0]              outl_ff;
   logic signed [SB-1:0]              outl_in;
   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   logic signed [SB-1:0]              rsp_left_ff;
   logic signed [SB-1:0]              rsp_left_in;
   logic signed [SB-1:0]              rsp_right_ff;
   logic signed [SB-1:0]              rsp_right_in;

   logic [sdlt_pkg::GAIN_W-1:0]         mix_q;
   logic [sdlt_pkg::GAIN_W-1:0]         width_q;
   logic signed [sdlt_pkg::MUL_B_W-1:0] mix_b;
   logic signed [sdlt_pkg::MUL_B_W-1:0] dry_b;
   logic signed [sdlt_pkg::MUL_B_W-1:0] width_b;
   logic signed [sdlt_pkg::MUL_B_W-1:0] mid_b;
   logic signed [sdlt_pkg::MUL_A_W-1:0] s_a;
   logic signed [sdlt_pkg::MUL_A_W-1:0] sum_a;
   logic signed [sdlt_pkg::SH_W-1:0]    acc_q16;
   logic signed [sdlt_pkg::SH_W-1:0]    acc_q17;
   logic signed [SB-1:0]                acc_sat;
   logic                                out_free;

   sdlt_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   sdlt_cos_rom u_cos_rom (
      .clock   (clock),
      .addr    (rom_addr),
      .rd_data (rom_data)
   );

   sdlt_mac u_mac (
      .clock (clock),
      .ctl   (mac_ctl),
      .acc   (acc)
   );

   assign mix_q   = sdlt_pkg::clamp_unity(cfg.wet_mix);
   assign width_q = sdlt_pkg::clamp_unity(cfg.stereo_width);
   assign mix_b   = $signed({2'b00, mix_q});
   assign dry_b   = $signed({2'b00, sdlt_pkg::GAIN_W'(sdlt_pkg::GAIN_UNITY - mix_q)});
   assign width_b = $signed({2'b00, width_q});
   assign mid_b   = $signed({2'b00, sdlt_pkg::GAIN_W'(sdlt_pkg::GAIN_UNITY - width_q)});
   assign s_a     = sdlt_pkg::MUL_A_W'(s_ff);
   assign sum_a   = sdlt_pkg::MUL_A_W'(shl_ff) + sdlt_pkg::MUL_A_W'(shr_ff);

   // Rounded results are floor shifts of the accumulator, which was preset to half an LSB.
   assign acc_q16 = acc[sdlt_pkg::SH_W+15:16];
   assign acc_q17 = acc[sdlt_pkg::SH_W+16:17];
   assign acc_sat = sdlt_pkg::sat_sample(acc[sdlt_pkg::PRE_W+15:16]);

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in       = state_ff;
      left_phase_in  = left_phase_ff;
      right_phase_in = right_phase_ff;
      s_in           = s_ff;
      env_l_in       = env_l_ff;
      env_r_in       = env_r_ff;
      shl_in         = shl_ff;
      shr_in         = shr_ff;
      wl_in          = wl_ff;
      wr_in          = wr_ff;
      outl_in        = outl_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_left_in    = rsp_left_ff;
      rsp_right_in   = rsp_right_ff;
      rom_addr       = left_phase_ff[PB-1 -: AW];
      mac_ctl.mul_en = 1'b0;
      mac_ctl.acc_op = sdlt_pkg::ACC_HOLD;
      mac_ctl.a      = s_a;
      mac_ctl.b      = env_l_ff;

      case (state_ff)
         sdlt_pkg::ST_IDLE: begin
            if (req_valid) begin
               s_in     = req_in_sample;
               state_in = sdlt_pkg::ST_ROM_L;
            end
         end
         sdlt_pkg::ST_ROM_L: begin
            state_in = sdlt_pkg::ST_ROM_R;
         end
         sdlt_pkg::ST_ROM_R: begin
            rom_addr = right_phase_ff[PB-1 -: AW];
            env_l_in = sdlt_pkg::ENV_UNITY + sdlt_pkg::ENV_W'(rom_data);
            state_in = sdlt_pkg::ST_SHL_MUL;
         end
         sdlt_pkg::ST_SHL_MUL: begin
            env_r_in       = sdlt_pkg::ENV_UNITY + sdlt_pkg::ENV_W'(rom_data);
            mac_ctl.mul_en = 1'b1;
            mac_ctl.acc_op = sdlt_pkg::ACC_INIT_Q16;
            state_in       = sdlt_pkg::ST_SHL_ADD;
         end
         sdlt_pkg::ST_SHR_MUL: begin
            shl_in         = acc_q16;
            mac_ctl.mul_en = 1'b1;
            mac_ctl.b      = env_r_ff;
            mac_ctl.acc_op = sdlt_pkg::ACC_INIT_Q16;
            state_in       = sdlt_pkg::ST_SHR_ADD;
         end
         sdlt_pkg::ST_WL_MUL1: begin
            shr_in         = acc_q16;
            mac_ctl.mul_en = 1'b1;
            mac_ctl.a      = sdlt_pkg::MUL_A_W'({shl_ff, 1'b0});
            mac_ctl.b      = width_b;
            mac_ctl.acc_op = sdlt_pkg::ACC_INIT_Q17;
            state_in       = sdlt_pkg::ST_WL_ADD1;
         end
         sdlt_pkg::ST_WL_MUL2: begin
            mac_ctl.mul_en = 1'b1;
            mac_ctl.a      = sum_a;
            mac_ctl.b      = mid_b;
            state_in       = sdlt_pkg::ST_WL_ADD2;
         end
         sdlt_pkg::ST_WR_MUL1: begin
            wl_in          = acc_q17;
            mac_ctl.mul_en = 1'b1;
            mac_ctl.a      = sdlt_pkg::MUL_A_W'({shr_ff, 1'b0});
            mac_ctl.b      = width_b;
            mac_ctl.acc_op = sdlt_pkg::ACC_INIT_Q17;
            state_in       = sdlt_pkg::ST_WR_ADD1;
         end
         sdlt_pkg::ST_WR_MUL2: begin
            mac_ctl.mul_en = 1'b1;
            mac_ctl.a      = sum_a;
            mac_ctl.b      = mid_b;
            state_in       = sdlt_pkg::ST_WR_ADD2;
         end
         sdlt_pkg::ST_OL_MUL1: begin
            wr_in          = acc_q17;
            mac_ctl.mul_en = 1'b1;
            mac_ctl.b      = dry_b;
            mac_ctl.acc_op = sdlt_pkg::ACC_INIT_Q16;
            state_in       = sdlt_pkg::ST_OL_ADD1;
         end
         sdlt_pkg::ST_OL_MUL2: begin
            mac_ctl.mul_en = 1'b1;
            mac_ctl.a      = sdlt_pkg::MUL_A_W'(wl_ff);
            mac_ctl.b      = mix_b;
            state_in       = sdlt_pkg::ST_OL_ADD2;
         end
         sdlt_pkg::ST_OR_MUL1: begin
            outl_in        = acc_sat;
            mac_ctl.mul_en = 1'b1;
            mac_ctl.b      = dry_b;
            mac_ctl.acc_op = sdlt_pkg::ACC_INIT_Q16;
            state_in       = sdlt_pkg::ST_OR_ADD1;
         end
         sdlt_pkg::ST_OR_MUL2: begin
            mac_ctl.mul_en = 1'b1;
            mac_ctl.a      = sdlt_pkg::MUL_A_W'(wr_ff);
            mac_ctl.b      = mix_b;
            state_in       = sdlt_pkg::ST_OR_ADD2;
         end
         sdlt_pkg::ST_SHL_ADD,
         sdlt_pkg::ST_SHR_ADD,
         sdlt_pkg::ST_WL_ADD1,
         sdlt_pkg::ST_WL_ADD2,
         sdlt_pkg::ST_WR_ADD1,
         sdlt_pkg::ST_WR_ADD2,
         sdlt_pkg::ST_OL_ADD1,
         sdlt_pkg::ST_OL_ADD2,
         sdlt_pkg::ST_OR_ADD1,
         sdlt_pkg::ST_OR_ADD2: begin
            mac_ctl.acc_op = sdlt_pkg::ACC_ADD;
            state_in       = sdlt_pkg::state_type'(state_ff + 5'd1);
         end
         sdlt_pkg::ST_DONE: begin
            // The phases move on only once the result has a place to go.
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_left_in    = outl_ff;
               rsp_right_in   = acc_sat;
               left_phase_in  = left_phase_ff + PB'(cfg.left_step);
               right_phase_in = right_phase_ff + PB'(cfg.right_step);
               state_in       = sdlt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sdlt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= sdlt_pkg::ST_IDLE;
         left_phase_ff  <= '0;
         right_phase_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         left_phase_ff  <= left_phase_in;
         right_phase_ff <= right_phase_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s_ff         <= s_in;
      env_l_ff     <= env_l_in;
      env_r_ff     <= env_r_in;
      shl_ff       <= shl_in;
      shr_ff       <= shr_in;
      wl_ff        <= wl_in;
      wr_ff        <= wr_in;
      outl_ff      <= outl_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
   end

   assign req_stall     = (state_ff != sdlt_pkg::ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_left_out  = rsp_left_ff;
   assign rsp_right_out = rsp_right_ff;

   a_accept_starts_rom: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == sdlt_pkg::ST_ROM_L))
      else $error("accepted transaction did not start the ROM reads");

   a_add_follows_mul: assert property (@(posedge clock) disable iff (reset)
      (mac_ctl.acc_op == sdlt_pkg::ACC_ADD) |-> $past(mac_ctl.mul_en))
      else $error("accumulate without a product issued the cycle before");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == sdlt_pkg::ST_DONE))
      else $error("result appeared outside the final sequencer state");

   a_phase_moves_on_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff != sdlt_pkg::ST_DONE) |=> $stable(left_phase_ff) && $stable(right_phase_ff))
      else $error("phase changed while no result was being delivered");

endmodule

`default_nettype wire
